[hdl/olsh_pkg.sv]
// ----------------------------------------------------------------------------
// olsh_pkg
// Shared types, codes and widths of the ordered key list with shuffle.
// ----------------------------------------------------------------------------
package olsh_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;

	localparam int KEY_W    = 64;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;
	localparam int ACTION_W = 2;
	localparam int SEED_W   = 32;
	// entry_key, position, padded to whole bytes
	localparam int ODATA_W  = ((KEY_W + POS_W + 7) / 8) * 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND  = 2'd0,
		ACT_REMOVE  = 2'd1,
		ACT_SHUFFLE = 2'd2,
		ACT_LIST    = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_TOO_FEW   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_CLR,
		IDX_INC,
		IDX_DEC,
		IDX_TOP
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_NEXT,
		RD_JDX
	} rd_src_t;

	typedef enum logic [1:0] {
		WR_TAIL,
		WR_IDX,
		WR_JDX
	} wr_src_t;

	typedef enum logic [1:0] {
		POS_ZERO,
		POS_COUNT,
		POS_IDX
	} pos_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APPEND,
		S_REPLY,
		S_REM_RD,
		S_REM_CMP,
		S_REM_ACK,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SHF_GEN,
		S_SHF_MOD,
		S_SHF_RDJ,
		S_SHF_WRI,
		S_SHF_WRJ,
		S_LST_RD,
		S_LST_OUT
	} state_t;

	typedef struct packed {
		logic     key_load;
		idx_op_t  idx_op;
		logic     jdx_load;
		logic     rd_en;
		rd_src_t  rd_src;
		logic     wr_en;
		wr_src_t  wr_src;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     gen_step;
		logic     push;
		status_t  out_status;
		pos_src_t pos_src;
		logic     key_en;
		logic     out_last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic few;
		logic idx_last;
		logic next_last;
		logic idx_one;
		logic match;
		logic out_free;
		logic mod_busy;
	} stat_t;

endpackage

[hdl/olsh_mod.sv]
// ----------------------------------------------------------------------------
// olsh_mod
// Bit-serial remainder unit: 32-bit dividend modulo a small divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module olsh_mod
	import olsh_pkg::*;
#(
	parameter int CW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SEED_W-1:0] dividend,
	input  logic [CW-1:0]     divisor,
	output logic              busy,
	output logic [CW-1:0]     rem
);

	localparam int STEP_W = $clog2(SEED_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [SEED_W-1:0] dvd_q;
	logic [CW-1:0]     dsr_q;
	logic [CW-1:0]     rem_q;
	logic [CW:0]       trial;
	logic [CW:0]       diff;

	assign trial = {rem_q, dvd_q[SEED_W-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(SEED_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SEED_W-2:0], 1'b0};
			// restore unless the trial covers the divisor
			if (trial >= {1'b0, dsr_q})
				rem_q <= diff[CW-1:0];
			else
				rem_q <= trial[CW-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

[hdl/olsh_dpath.sv]
// ----------------------------------------------------------------------------
// olsh_dpath
// Datapath: key store, loop indices, entry count, generator, output register.
// ----------------------------------------------------------------------------
module olsh_dpath
	import olsh_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [KEY_W-1:0]    in_key,
	input  logic                cfg_we,
	input  logic [SEED_W-1:0]   cfg_seed,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [KEY_W-1:0]    out_key,
	output logic [POS_W-1:0]    out_pos,
	output logic                out_last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [KEY_BITS-1:0] mem_q [DEPTH];
	logic [KEY_BITS-1:0] rdata_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] hold_q;
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       jdx_q;
	logic [CW-1:0]       cnt_q;
	logic [SEED_W-1:0]   gen_q;
	logic [SEED_W-1:0]   gen_next;

	logic                ovalid_q;
	logic [STATUS_W-1:0] ostatus_q;
	logic [KEY_BITS-1:0] okey_q;
	logic [POS_W-1:0]    opos_q;
	logic                olast_q;

	logic [CW:0]         idx_w;
	logic [CW:0]         cnt_w;
	logic [AW+POS_W-1:0] idx_x;
	logic [CW+POS_W-1:0] cnt_x;
	logic [AW-1:0]       raddr;
	logic [AW-1:0]       waddr;
	logic [KEY_BITS-1:0] wdata;
	logic [POS_W-1:0]    pos_sel;
	logic [CW-1:0]       divisor;
	logic                mod_busy;
	logic [CW-1:0]       mod_rem;
	logic                out_free;

	function automatic logic [SEED_W-1:0] xs_step(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	assign gen_next = xs_step(gen_q);
	assign idx_w    = (CW+1)'(idx_q);
	assign cnt_w    = (CW+1)'(cnt_q);
	assign idx_x    = (AW+POS_W)'(idx_q);
	assign cnt_x    = (CW+POS_W)'(cnt_q);
	assign divisor  = CW'(idx_w + 1'b1);
	assign out_free = !ovalid_q || out_ready;

	olsh_mod #(
		.CW(CW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.gen_step),
		.dividend (gen_next),
		.divisor  (divisor),
		.busy     (mod_busy),
		.rem      (mod_rem)
	);

	always_comb begin
		unique case (cmd.rd_src)
			RD_IDX:  raddr = idx_q;
			RD_NEXT: raddr = AW'(idx_w + 1'b1);
			RD_JDX:  raddr = jdx_q;
			default: raddr = idx_q;
		endcase
		unique case (cmd.wr_src)
			WR_TAIL: begin
				waddr = cnt_q[AW-1:0];
				wdata = key_q;
			end
			WR_IDX: begin
				waddr = idx_q;
				wdata = rdata_q;
			end
			WR_JDX: begin
				waddr = jdx_q;
				wdata = hold_q;
			end
			default: begin
				waddr = idx_q;
				wdata = rdata_q;
			end
		endcase
		unique case (cmd.pos_src)
			POS_ZERO:  pos_sel = '0;
			POS_COUNT: pos_sel = cnt_x[POS_W-1:0];
			POS_IDX:   pos_sel = idx_x[POS_W-1:0];
			default:   pos_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem_q[waddr] <= wdata;
		if (cmd.rd_en)
			rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load)
			key_q <= in_key[KEY_BITS-1:0];
		if (cmd.jdx_load) begin
			jdx_q  <= mod_rem[AW-1:0];
			hold_q <= rdata_q;
		end
		if (cmd.push) begin
			ostatus_q <= cmd.out_status;
			okey_q    <= cmd.key_en ? rdata_q : '0;
			opos_q    <= pos_sel;
			olast_q   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			gen_q    <= SEED_W'(1);
			ovalid_q <= 1'b0;
		end else begin
			unique case (cmd.idx_op)
				IDX_HOLD: idx_q <= idx_q;
				IDX_CLR:  idx_q <= '0;
				IDX_INC:  idx_q <= AW'(idx_w + 1'b1);
				IDX_DEC:  idx_q <= idx_q - 1'b1;
				IDX_TOP:  idx_q <= AW'(cnt_w - 1'b1);
				default:  idx_q <= idx_q;
			endcase
			if (cmd.cnt_inc)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - 1'b1;
			// a zero seed would lock the generator at zero
			if (cfg_we)
				gen_q <= (cfg_seed == '0) ? SEED_W'(1) : cfg_seed;
			else if (cmd.gen_step)
				gen_q <= gen_next;
			if (cmd.push)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.full      = (cnt_q == CW'(DEPTH));
		stat.empty     = (cnt_q == '0);
		stat.few       = (cnt_q < CW'(2));
		stat.idx_last  = ((idx_w + 1'b1) == cnt_w);
		stat.next_last = ((idx_w + 2'd2) == cnt_w);
		stat.idx_one   = (idx_w == (CW+1)'(1));
		stat.match     = (rdata_q == key_q);
		stat.out_free  = out_free;
		stat.mod_busy  = mod_busy;
	end

	always_comb begin
		out_key = '0;
		out_key[KEY_BITS-1:0] = okey_q;
	end

	assign out_valid  = ovalid_q;
	assign out_status = ostatus_q;
	assign out_pos    = opos_q;
	assign out_last   = olast_q;

endmodule

[hdl/olsh_ctrl.sv]
// ----------------------------------------------------------------------------
// olsh_ctrl
// Controller: sequences append, remove, shuffle and list over the datapath.
// ----------------------------------------------------------------------------
module olsh_ctrl
	import olsh_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] in_action,
	input  stat_t               stat,
	output cmd_t                cmd
);

	state_t  state_q, state_d;
	status_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		st_d     = st_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx_op     = IDX_HOLD;
		cmd.rd_src     = RD_IDX;
		cmd.wr_src     = WR_IDX;
		cmd.out_status = ST_OK;
		cmd.pos_src    = POS_ZERO;

		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.key_load = in_valid;
				if (in_valid) begin
					unique case (action_t'(in_action))
						ACT_APPEND: begin
							if (stat.full) begin
								st_d    = ST_FULL;
								state_d = S_REPLY;
							end else begin
								state_d = S_APPEND;
							end
						end
						ACT_REMOVE: begin
							if (stat.empty) begin
								st_d    = ST_EMPTY;
								state_d = S_REPLY;
							end else begin
								cmd.idx_op = IDX_CLR;
								state_d    = S_REM_RD;
							end
						end
						ACT_SHUFFLE: begin
							if (stat.few) begin
								st_d    = ST_TOO_FEW;
								state_d = S_REPLY;
							end else begin
								cmd.idx_op = IDX_TOP;
								state_d    = S_SHF_GEN;
							end
						end
						ACT_LIST: begin
							if (stat.empty) begin
								st_d    = ST_EMPTY;
								state_d = S_REPLY;
							end else begin
								cmd.idx_op = IDX_CLR;
								state_d    = S_LST_RD;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_APPEND: begin
				if (stat.out_free) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_src   = WR_TAIL;
					cmd.cnt_inc  = 1'b1;
					cmd.push     = 1'b1;
					cmd.pos_src  = POS_COUNT;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					cmd.push       = 1'b1;
					cmd.out_status = st_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_REM_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_REM_CMP;
			end
			S_REM_CMP: begin
				priority if (stat.match) begin
					state_d = S_REM_ACK;
				end else if (stat.idx_last) begin
					st_d    = ST_NOT_FOUND;
					state_d = S_REPLY;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_REM_RD;
				end
			end
			S_REM_ACK: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.pos_src  = POS_IDX;
					cmd.out_last = 1'b1;
					if (stat.idx_last) begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end
			end
			S_SHIFT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_NEXT;
				state_d    = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// close the gap one entry at a time
				cmd.wr_en  = 1'b1;
				cmd.wr_src = WR_IDX;
				cmd.idx_op = IDX_INC;
				if (stat.next_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SHF_GEN: begin
				cmd.gen_step = 1'b1;
				cmd.rd_en    = 1'b1;
				state_d      = S_SHF_MOD;
			end
			S_SHF_MOD: begin
				if (!stat.mod_busy) begin
					cmd.jdx_load = 1'b1;
					state_d      = S_SHF_RDJ;
				end
			end
			S_SHF_RDJ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_JDX;
				state_d    = S_SHF_WRI;
			end
			S_SHF_WRI: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = WR_IDX;
				state_d    = S_SHF_WRJ;
			end
			S_SHF_WRJ: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = WR_JDX;
				if (stat.idx_one) begin
					st_d    = ST_OK;
					state_d = S_REPLY;
				end else begin
					cmd.idx_op = IDX_DEC;
					state_d    = S_SHF_GEN;
				end
			end
			S_LST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LST_OUT;
			end
			S_LST_OUT: begin
				if (stat.out_free) begin
					cmd.push     = 1'b1;
					cmd.key_en   = 1'b1;
					cmd.pos_src  = POS_IDX;
					cmd.out_last = stat.idx_last;
					if (stat.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_op = IDX_INC;
						state_d    = S_LST_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/ordered_list_with_shuffle.sv]
// ----------------------------------------------------------------------------
// ordered_list_with_shuffle
// Ordered list of keys with append, remove, Fisher-Yates shuffle and list.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per beat: tuser holds the action, tdata the
//   key. m_axis returns results: tuser the status, tdata the entry key and
//   position, tlast the final beat of a command. cfg writes the generator
//   seed; write it only while no command is in flight.
// Sequencing (n entries):
//   append: the key is written at the tail; remove: entries are compared
//   in order, the result is reported, then every entry behind it moves up
//   to close the gap; list: each entry is read, then sent as one beat;
//   shuffle: n-1 swaps, each paced by the bit-serial remainder unit.
//   A new command is taken once the previous one has finished, including
//   the gap closing that follows the result beat of a remove.
// Reset clears the list, the generator loads seed 1, no beat is pending.
// When m_axis stalls, the held result stays in the output register and
// the sequencer waits before producing the next beat.
// ----------------------------------------------------------------------------
module ordered_list_with_shuffle
	import olsh_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [KEY_W-1:0]    s_axis_tdata,   // key
	input  logic [ACTION_W-1:0] s_axis_tuser,   // action
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [ODATA_W-1:0]  m_axis_tdata,   // entry_key, position, zero pad
	output logic [STATUS_W-1:0] m_axis_tuser,   // status
	output logic                m_axis_tlast,   // last_result
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SEED_W-1:0]   cfg_data        // random_seed
);

	cmd_t             cmd;
	stat_t            stat;
	logic [KEY_W-1:0] out_key;
	logic [POS_W-1:0] out_pos;

	assign cfg_ready = 1'b1;

	olsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.stat      (stat),
		.cmd       (cmd)
	);

	olsh_dpath #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_key     (s_axis_tdata),
		.cfg_we     (cfg_valid),
		.cfg_seed   (cfg_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_key    (out_key),
		.out_pos    (out_pos),
		.out_last   (m_axis_tlast)
	);

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[KEY_W-1:0] = out_key;
		m_axis_tdata[KEY_W+POS_W-1:KEY_W] = out_pos;
	end

endmodule

[tb/sv/tb_ordered_list_with_shuffle.sv]
// ----------------------------------------------------------------------------
// tb_ordered_list_with_shuffle
// Self-checking bench for the ordered key list with append, remove, shuffle
// and list. Commands go in on s_axis; a behavioral copy of the list and of
// the xorshift32 generator predicts every result beat, and each beat taken
// from m_axis is checked field by field against the oldest prediction.
// Directed tests cover empty and full lists, duplicate keys, seed loading
// and a long output stall; a random mix with varying idle gaps follows.
// ----------------------------------------------------------------------------
module tb_ordered_list_with_shuffle;
	import olsh_pkg::*;

	localparam int LIST_DEPTH    = DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 10;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		status_t          status;
		logic [KEY_W-1:0] entry_key;
		logic [POS_W-1:0] position;
		logic             last;
	} list_beat_t;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [KEY_W-1:0]    s_axis_tdata;   // key
	logic [ACTION_W-1:0] s_axis_tuser;   // action
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [ODATA_W-1:0]  m_axis_tdata;   // entry_key, position, zero pad
	logic [STATUS_W-1:0] m_axis_tuser;   // status
	logic                m_axis_tlast;   // last_result
	logic                cfg_valid;
	logic                cfg_ready;
	logic [SEED_W-1:0]   cfg_data;       // random_seed

	// predicted list contents and generator
	logic [KEY_W-1:0]  stored_keys [LIST_DEPTH];
	int                stored_count;
	logic [SEED_W-1:0] shuffle_state;

	list_beat_t pending_beats[$];
	int         err_count;
	int         tx_max_gap;
	int         rx_max_gap;
	int         rx_hold_len;
	bit         rx_hold_req;

	ordered_list_with_shuffle u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [SEED_W-1:0] next_random();
		logic [SEED_W-1:0] x;
		x = shuffle_state;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		shuffle_state = x;
		return x;
	endfunction

	function automatic void push_beat(status_t st, logic [KEY_W-1:0] k,
			logic [POS_W-1:0] pos, logic last);
		list_beat_t b;
		b.status    = st;
		b.entry_key = k;
		b.position  = pos;
		b.last      = last;
		pending_beats.push_back(b);
	endfunction

	function automatic void apply_list_cmd(action_t act, logic [KEY_W-1:0] key);
		int i;
		int j;
		int hit;
		logic [KEY_W-1:0] t;
		case (act)
			ACT_APPEND: begin
				if (stored_count >= LIST_DEPTH) begin
					push_beat(ST_FULL, '0, '0, 1'b1);
				end else begin
					stored_keys[stored_count] = key;
					push_beat(ST_OK, '0, POS_W'(stored_count), 1'b1);
					stored_count++;
				end
			end
			ACT_REMOVE: begin
				if (stored_count == 0) begin
					push_beat(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					hit = -1;
					for (i = 0; i < stored_count; i++)
						if (hit < 0 && stored_keys[i] == key) hit = i;
					if (hit < 0) begin
						push_beat(ST_NOT_FOUND, '0, '0, 1'b1);
					end else begin
						push_beat(ST_OK, '0, POS_W'(hit), 1'b1);
						for (i = hit; i + 1 < stored_count; i++)
							stored_keys[i] = stored_keys[i+1];
						stored_count--;
					end
				end
			end
			ACT_SHUFFLE: begin
				if (stored_count < 2) begin
					push_beat(ST_TOO_FEW, '0, '0, 1'b1);
				end else begin
					for (i = stored_count - 1; i > 0; i--) begin
						j = int'(next_random() % 32'(i + 1));
						t = stored_keys[i];
						stored_keys[i] = stored_keys[j];
						stored_keys[j] = t;
					end
					push_beat(ST_OK, '0, '0, 1'b1);
				end
			end
			default: begin
				if (stored_count == 0) begin
					push_beat(ST_EMPTY, '0, '0, 1'b1);
				end else begin
					for (i = 0; i < stored_count; i++)
						push_beat(ST_OK, stored_keys[i], POS_W'(i),
							i + 1 == stored_count);
				end
			end
		endcase
	endfunction

	// offer one command after a random gap; predict at the accepting edge
	task automatic send_cmd(action_t act, logic [KEY_W-1:0] key);
		int gap;
		gap = (tx_max_gap > 0) ? $urandom_range(0, tx_max_gap) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= key;
		do @(posedge clk); while (!s_axis_tready);
		apply_list_cmd(act, key);
	endtask

	// drop valid, wait for every predicted beat and for the block to go idle
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(logic [SEED_W-1:0] seed);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= seed;
		do @(posedge clk); while (!cfg_ready);
		shuffle_state = (seed == '0) ? SEED_W'(1) : seed;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: per-beat random gap, plus a long hold-off on request
	initial begin : rx_proc
		int gap_left;
		int hold_left;
		gap_left  = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				gap_left = (rx_max_gap > 0) ? $urandom_range(0, rx_max_gap) : 0;
			if (rx_hold_req) begin
				hold_left   = rx_hold_len;
				rx_hold_req = 1'b0;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		list_beat_t got;
		list_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status    = status_t'(m_axis_tuser);
			got.entry_key = m_axis_tdata[KEY_W-1:0];
			got.position  = m_axis_tdata[KEY_W +: POS_W];
			got.last      = m_axis_tlast;
			if (pending_beats.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_MAX)
					$display("unexpected beat: status %0d key %h pos %0d last %b",
						got.status, got.entry_key, got.position, got.last);
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= REPORT_MAX)
						$display({"mismatch: want status %0d key %h pos %0d last %b,",
							" got status %0d key %h pos %0d last %b"},
							want.status, want.entry_key, want.position, want.last,
							got.status, got.entry_key, got.position, got.last);
				end
			end
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic test_empty_list();
		send_cmd(ACT_LIST, '0);
		send_cmd(ACT_REMOVE, 64'h1);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_APPEND, '0);
		// one entry is still too few to shuffle
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_cmd(ACT_REMOVE, '0);
	endtask

	task automatic test_fill_to_full();
		logic [KEY_W-1:0] fill_keys [LIST_DEPTH];
		int i;
		fill_keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0000, 64'h1,
			64'h5555_5555_5555_5555, 64'h0123_4567_89AB_CDEF, 64'h7FFF_FFFF_FFFF_FFFF,
			64'hFEDC_BA98_7654_3210, 64'h5555_5555_5555_5555, 64'h2, 64'h3,
			64'hDEAD_BEEF_0000_0001, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF};
		for (i = 0; i < LIST_DEPTH; i++)
			send_cmd(ACT_APPEND, fill_keys[i]);
		send_cmd(ACT_APPEND, 64'h9);
		send_cmd(ACT_LIST, '0);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_LIST, '0);
	endtask

	task automatic test_remove_order();
		// first of the duplicates goes, then both ends, the middle and a missing key
		send_cmd(ACT_REMOVE, 64'h5555_5555_5555_5555);
		send_cmd(ACT_REMOVE, stored_keys[stored_count-1]);
		send_cmd(ACT_REMOVE, stored_keys[0]);
		send_cmd(ACT_REMOVE, stored_keys[stored_count/2]);
		send_cmd(ACT_REMOVE, 64'h4444_4444_4444_4444);
		send_cmd(ACT_LIST, '0);
	endtask

	task automatic test_seed_values();
		// zero seed must behave as seed one
		write_seed('0);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_LIST, '0);
		write_seed(32'hFFFF_FFFF);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_LIST, '0);
		write_seed(32'h1);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_LIST, '0);
	endtask

	task automatic test_output_stall();
		settle();
		rx_hold_len = HOLD_CYCLES;
		rx_hold_req = 1'b1;
		send_cmd(ACT_LIST, '0);
		send_cmd(ACT_LIST, '0);
		send_cmd(ACT_SHUFFLE, '0);
		send_cmd(ACT_APPEND, 64'hC3C3_C3C3_C3C3_C3C3);
		send_cmd(ACT_APPEND, 64'h3C3C_3C3C_3C3C_3C3C);
		send_cmd(ACT_APPEND, 64'h6);
		send_cmd(ACT_APPEND, 64'h7);
		send_cmd(ACT_LIST, '0);
	endtask

	task automatic test_random_mix(int n_items, int tx_gap, int rx_gap);
		int k;
		int pick;
		bit grow;
		action_t act;
		logic [KEY_W-1:0] key;
		write_seed($urandom);
		tx_max_gap = tx_gap;
		rx_max_gap = rx_gap;
		grow = (stored_count < LIST_DEPTH / 2);
		for (k = 0; k < n_items; k++) begin
			// swing between full and empty so both ends get exercised
			if (stored_count == LIST_DEPTH) grow = 1'b0;
			if (stored_count == 0) grow = 1'b1;
			pick = $urandom_range(0, 99);
			if (pick < (grow ? 55 : 15))       act = ACT_APPEND;
			else if (pick < 70)                act = ACT_REMOVE;
			else if (pick < 85)                act = ACT_SHUFFLE;
			else                               act = ACT_LIST;
			if ($urandom_range(0, 3) == 0) key = KEY_W'($urandom_range(0, 7));
			else                           key = {$urandom, $urandom};
			if (act == ACT_REMOVE && stored_count > 0 && $urandom_range(0, 3) != 0)
				key = stored_keys[$urandom_range(0, stored_count - 1)];
			send_cmd(act, key);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_APPEND;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		stored_count  = 0;
		shuffle_state = SEED_W'(1);
		err_count     = 0;
		tx_max_gap    = 15;
		rx_max_gap    = 15;
		rx_hold_len   = 0;
		rx_hold_req   = 1'b0;
		foreach (stored_keys[i]) stored_keys[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_fill_to_full();
		test_remove_order();
		test_seed_values();
		test_output_stall();
		test_random_mix(20, 15, 15);
		test_random_mix(20, 0, 0);
		test_random_mix(20, 15, 0);
		test_random_mix(20, 0, 15);
		settle();
		repeat (20) @(posedge clk);

		if (err_count == 0 && pending_beats.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
hdl/olsh_pkg.sv
hdl/olsh_mod.sv
hdl/olsh_dpath.sv
hdl/olsh_ctrl.sv
hdl/ordered_list_with_shuffle.sv
tb/sv/tb_ordered_list_with_shuffle.sv
